@@ hw/rtl/stvc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Steiner tree check package
// Shared sizes, codes and the command and status types between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package stvc_pkg;

    localparam int MaxPins    = 16;
    localparam int MaxEdges   = 32;
    localparam int MaxVerts   = 64;
    localparam int CoordBits  = 8;

    localparam int PinAw   = $clog2(MaxPins);
    localparam int PinCw   = $clog2(MaxPins + 1);
    localparam int EdgeAw  = $clog2(MaxEdges);
    localparam int EdgeCw  = $clog2(MaxEdges + 1);
    localparam int VertAw  = $clog2(MaxVerts);
    localparam int VertCw  = $clog2(MaxVerts + 1);
    localparam int DegW    = $clog2(2 * MaxEdges + 1);
    localparam int PointW  = 2 * CoordBits;
    localparam int KeyW    = 2 * PointW;
    localparam int VentW   = PointW + DegW;
    localparam int StackAw = $clog2(MaxEdges + 1);
    localparam int StackCw = $clog2(MaxEdges + 2);
    localparam int IdxW    = VertCw;

    typedef enum logic [1:0] {
        ACT_PIN  = 2'd0,
        ACT_EDGE = 2'd1,
        ACT_EVAL = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        RSN_OK        = 3'd0,
        RSN_DUPLICATE = 3'd1,
        RSN_DEGREE    = 3'd2,
        RSN_COUNT     = 3'd3,
        RSN_CYCLE     = 3'd4,
        RSN_UNREACHED = 3'd5,
        RSN_OVERFLOW  = 3'd6
    } t_reason;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_PIN,
        OP_EDGE_START,
        OP_INS,
        OP_EVAL_START,
        OP_DUP,
        OP_COPY,
        OP_EP_SET,
        OP_EP_RD,
        OP_EP_CHK,
        OP_DEG_RD,
        OP_DEG_CHK,
        OP_WALK,
        OP_POP,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic fail;
        logic pass;
        logic scan_end;
        logic hit;
        logic pop;
        logic full;
    } t_status;

endpackage
`default_nettype wire

@@ hw/rtl/steiner_tree_validity_check_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Steiner tree validity check
// Loads pins and edges, then checks on request that the edges form a tree.
// ----------------------------------------------------------------------------
// Usage: raise start with an action while busy is low; the beat is taken at
// that edge. Action 0 loads a pin and finishes in the same cycle. Action 1
// inserts an edge into the sorted edge store, one shift per cycle. Action 2
// evaluates: a duplicate scan over the edges, a copy of the pins into the
// vertex table, a search of that table for every edge endpoint (each entry
// visited is first read and then compared, as the vertex memory has a single
// read port), a degree scan, and a depth-first walk that rescans the edge
// list for each step. Evaluate then drives o_valid for exactly one cycle
// with o_tree_ok and o_fail_reason; the stores are then empty. Action 3 does
// nothing. The receiver cannot stall: the result beat is shown once and must
// be taken. A synchronous active-low reset empties all stores, clears the
// overflow flag and returns the block to idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
module steiner_tree_validity_check_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_first_x,
    input  wire logic [7:0]  i_first_y,
    input  wire logic [7:0]  i_second_x,
    input  wire logic [7:0]  i_second_y,
    output logic             busy,
    output logic             o_valid,
    output logic             o_tree_ok,
    output logic [2:0]       o_fail_reason
);

    // Command from the controller and status back from the datapath.
    stvc_pkg::t_cmd    cmd;
    stvc_pkg::t_status status;

    stvc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    stvc_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_first_x     (i_first_x),
        .i_first_y     (i_first_y),
        .i_second_x    (i_second_x),
        .i_second_y    (i_second_y),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_tree_ok     (o_tree_ok),
        .o_fail_reason (o_fail_reason)
    );

endmodule
`default_nettype wire

@@ hw/rtl/stvc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Steiner tree check controller
// One-hot state machine that sequences the load and evaluate phases.
// ----------------------------------------------------------------------------
module stvc_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire logic [1:0]       i_action,
    input  stvc_pkg::t_status     i_status,
    output stvc_pkg::t_cmd        o_cmd,
    output logic                  busy
);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_INS     = 12'b0000_0000_0010,
        S_DUP     = 12'b0000_0000_0100,
        S_COPY    = 12'b0000_0000_1000,
        S_EP_SET  = 12'b0000_0001_0000,
        S_EP_RD   = 12'b0000_0010_0000,
        S_EP_CHK  = 12'b0000_0100_0000,
        S_DEG_RD  = 12'b0000_1000_0000,
        S_DEG_CHK = 12'b0001_0000_0000,
        S_WALK    = 12'b0010_0000_0000,
        S_POP     = 12'b0100_0000_0000,
        S_DONE    = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    stvc_pkg::t_op op;

    assign busy     = (r_state != S_IDLE);
    assign o_cmd.op = op;

    always_comb begin
        n_state = r_state;
        op      = stvc_pkg::OP_NOP;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (stvc_pkg::t_action'(i_action))
                        stvc_pkg::ACT_PIN: begin
                            op = stvc_pkg::OP_PIN;
                        end
                        stvc_pkg::ACT_EDGE: begin
                            op = stvc_pkg::OP_EDGE_START;
                            if (!i_status.full) n_state = S_INS;
                        end
                        stvc_pkg::ACT_EVAL: begin
                            op = stvc_pkg::OP_EVAL_START;
                            n_state = i_status.fail ? S_DONE : S_DUP;
                        end
                        default: begin
                            op = stvc_pkg::OP_NOP;
                        end
                    endcase
                end
            end
            S_INS: begin
                op = stvc_pkg::OP_INS;
                if (i_status.scan_end) n_state = S_IDLE;
            end
            S_DUP: begin
                op = stvc_pkg::OP_DUP;
                if (i_status.fail) n_state = S_DONE;
                else if (i_status.scan_end) n_state = S_COPY;
            end
            S_COPY: begin
                op = stvc_pkg::OP_COPY;
                if (i_status.scan_end) n_state = S_EP_SET;
            end
            S_EP_SET: begin
                op = stvc_pkg::OP_EP_SET;
                n_state = i_status.scan_end ? S_DEG_RD : S_EP_RD;
            end
            S_EP_RD: begin
                op = stvc_pkg::OP_EP_RD;
                if (i_status.fail) n_state = S_DONE;
                else if (i_status.hit) n_state = S_EP_SET;
                else n_state = S_EP_CHK;
            end
            S_EP_CHK: begin
                op = stvc_pkg::OP_EP_CHK;
                n_state = i_status.hit ? S_EP_SET : S_EP_RD;
            end
            S_DEG_RD: begin
                op = stvc_pkg::OP_DEG_RD;
                if (i_status.fail) n_state = S_DONE;
                else if (i_status.scan_end) n_state = S_WALK;
                else n_state = S_DEG_CHK;
            end
            S_DEG_CHK: begin
                op = stvc_pkg::OP_DEG_CHK;
                n_state = i_status.fail ? S_DONE : S_DEG_RD;
            end
            S_WALK: begin
                op = stvc_pkg::OP_WALK;
                if (i_status.fail || i_status.pass) n_state = S_DONE;
                else if (i_status.pop) n_state = S_POP;
            end
            S_POP: begin
                op = stvc_pkg::OP_POP;
                n_state = S_WALK;
            end
            S_DONE: begin
                op = stvc_pkg::OP_EMIT;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/stvc_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Steiner tree check datapath
// Pin and edge stores, vertex table memory, walk stack and scan counters.
// ----------------------------------------------------------------------------
module stvc_dpath (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  stvc_pkg::t_cmd            i_cmd,
    input  wire logic [7:0]           i_first_x,
    input  wire logic [7:0]           i_first_y,
    input  wire logic [7:0]           i_second_x,
    input  wire logic [7:0]           i_second_y,
    output stvc_pkg::t_status         o_status,
    output logic                      o_valid,
    output logic                      o_tree_ok,
    output logic [2:0]                o_fail_reason
);

    localparam int PW = stvc_pkg::PointW;
    localparam int DW = stvc_pkg::DegW;

    // Stores.
    logic [PW-1:0]                  r_pin  [stvc_pkg::MaxPins];
    logic [stvc_pkg::KeyW-1:0]      r_edge [stvc_pkg::MaxEdges];
    logic [stvc_pkg::VertAw-1:0]    r_end0 [stvc_pkg::MaxEdges];
    logic [stvc_pkg::VertAw-1:0]    r_end1 [stvc_pkg::MaxEdges];
    logic [stvc_pkg::VentW-1:0]     vmem   [stvc_pkg::MaxVerts];
    logic [stvc_pkg::VertAw-1:0]    smem   [2**stvc_pkg::StackAw];

    // Control and scan registers.
    logic [stvc_pkg::PinCw-1:0]     r_pin_cnt;
    logic [stvc_pkg::EdgeCw-1:0]    r_edge_cnt;
    logic                           r_ovf;
    logic [stvc_pkg::MaxEdges-1:0]  r_used;
    logic [stvc_pkg::MaxVerts-1:0]  r_seen;
    logic [stvc_pkg::VertCw-1:0]    r_vcnt;
    logic [stvc_pkg::IdxW-1:0]      r_idx;
    logic [stvc_pkg::EdgeCw-1:0]    r_e;
    logic                           r_side;
    logic [PW-1:0]                  r_point;
    logic [stvc_pkg::KeyW-1:0]      r_key;
    logic [stvc_pkg::KeyW-1:0]      r_prev;
    logic [stvc_pkg::VertAw-1:0]    r_cur;
    logic [stvc_pkg::VertAw-1:0]    r_first;
    logic                           r_first_ok;
    logic [stvc_pkg::StackCw-1:0]   r_sp;
    logic [2:0]                     r_reason;
    logic                           r_valid;
    logic                           r_ok;
    logic [2:0]                     r_fr;
    logic [stvc_pkg::VentW-1:0]     r_vrd;
    logic [stvc_pkg::VertAw-1:0]    r_srd;

    // Combinational helpers.
    logic [PW-1:0]                  pt1, pt2;
    logic [stvc_pkg::KeyW-1:0]      key_in;
    logic [stvc_pkg::EdgeAw-1:0]    pos, pos_m1, e5;
    logic [stvc_pkg::KeyW-1:0]      es_prev, es_cur, es_e;
    logic                           ins_shift, dup_end, dup_hit, copy_end, ep_end;
    logic                           app, vfull, match, deg_end, cnt_bad, bad_deg;
    logic [DW-1:0]                  deg;
    logic                           w_end, hit0, hit1, w_hit, sp_last, pins_ok;
    logic [stvc_pkg::VertAw-1:0]    nxt, start_v;
    logic [stvc_pkg::MaxPins-1:0]   pin_mask;

    logic                           vm_we, vm_re;
    logic [stvc_pkg::VertAw-1:0]    vm_wa, vm_ra;
    logic [stvc_pkg::VentW-1:0]     vm_wd;
    logic                           sm_we, sm_re;
    logic [stvc_pkg::StackAw-1:0]   sm_wa, sm_ra;
    logic [stvc_pkg::VertAw-1:0]    sm_wd;
    logic                           end_we;
    logic [stvc_pkg::VertAw-1:0]    end_wd;

    assign pt1    = {i_first_x, i_first_y};
    assign pt2    = {i_second_x, i_second_y};
    assign key_in = {pt1, pt2};

    assign pos       = r_idx[stvc_pkg::EdgeAw-1:0];
    assign pos_m1    = pos - 1'b1;
    assign es_prev   = r_edge[pos_m1];
    assign es_cur    = r_edge[pos];
    assign ins_shift = (r_idx != '0) && (es_prev > r_key);
    assign dup_end   = r_idx >= stvc_pkg::IdxW'(r_edge_cnt);
    assign dup_hit   = !dup_end && (r_idx != '0) && (es_cur == r_prev);
    assign copy_end  = r_idx >= stvc_pkg::IdxW'(r_pin_cnt);

    assign e5     = r_e[stvc_pkg::EdgeAw-1:0];
    assign es_e   = r_edge[e5];
    assign ep_end = r_e >= r_edge_cnt;

    assign app     = r_idx >= r_vcnt;
    assign vfull   = r_vcnt >= stvc_pkg::VertCw'(stvc_pkg::MaxVerts);
    assign match   = r_vrd[stvc_pkg::VentW-1:DW] == r_point;
    assign deg     = r_vrd[DW-1:0];
    assign deg_end = r_idx >= r_vcnt;
    assign cnt_bad = (stvc_pkg::VertCw'(r_edge_cnt) + 1'b1) != r_vcnt;
    assign bad_deg = (r_idx < stvc_pkg::IdxW'(r_pin_cnt)) ? (deg == '0)
                                                          : (deg == DW'(1));
    assign start_v = r_first_ok ? r_first : '0;

    assign w_end   = r_e >= r_edge_cnt;
    assign hit0    = r_end0[e5] == r_cur;
    assign hit1    = r_end1[e5] == r_cur;
    assign w_hit   = !w_end && !r_used[e5] && (hit0 || hit1);
    assign nxt     = hit0 ? r_end1[e5] : r_end0[e5];
    assign sp_last = r_sp == stvc_pkg::StackCw'(1);

    always_comb begin
        for (int k = 0; k < stvc_pkg::MaxPins; k++) begin
            pin_mask[k] = stvc_pkg::PinCw'(k) < r_pin_cnt;
        end
    end
    assign pins_ok = &(r_seen[stvc_pkg::MaxPins-1:0] | ~pin_mask);

    // Status back to the controller.
    always_comb begin
        o_status = '0;
        case (i_cmd.op)
            stvc_pkg::OP_EDGE_START: o_status.full = r_edge_cnt >=
                                         stvc_pkg::EdgeCw'(stvc_pkg::MaxEdges);
            stvc_pkg::OP_INS:        o_status.scan_end = !ins_shift;
            stvc_pkg::OP_EVAL_START: o_status.fail = r_ovf;
            stvc_pkg::OP_DUP: begin
                o_status.scan_end = dup_end;
                o_status.fail     = dup_hit;
            end
            stvc_pkg::OP_COPY:       o_status.scan_end = copy_end;
            stvc_pkg::OP_EP_SET:     o_status.scan_end = ep_end;
            stvc_pkg::OP_EP_RD: begin
                o_status.fail = app && vfull;
                o_status.hit  = app && !vfull;
            end
            stvc_pkg::OP_EP_CHK:     o_status.hit = match;
            stvc_pkg::OP_DEG_RD: begin
                o_status.scan_end = deg_end;
                o_status.fail     = deg_end && cnt_bad;
            end
            stvc_pkg::OP_DEG_CHK:    o_status.fail = bad_deg;
            stvc_pkg::OP_WALK: begin
                o_status.fail = (w_hit && r_seen[nxt]) || (w_end && sp_last && !pins_ok);
                o_status.pass = w_end && sp_last && pins_ok;
                o_status.pop  = w_end && !sp_last;
            end
            default: o_status = '0;
        endcase
    end

    // Memory and table port controls.
    always_comb begin
        vm_we  = 1'b0;
        vm_wa  = r_idx[stvc_pkg::VertAw-1:0];
        vm_wd  = {r_point, DW'(1)};
        vm_re  = 1'b0;
        vm_ra  = r_idx[stvc_pkg::VertAw-1:0];
        sm_we  = 1'b0;
        sm_wa  = r_sp[stvc_pkg::StackAw-1:0];
        sm_wd  = nxt;
        sm_re  = 1'b0;
        sm_ra  = stvc_pkg::StackAw'(r_sp - stvc_pkg::StackCw'(2));
        end_we = 1'b0;
        end_wd = r_vcnt[stvc_pkg::VertAw-1:0];
        case (i_cmd.op)
            stvc_pkg::OP_COPY: begin
                vm_we = !copy_end;
                vm_wd = {r_pin[r_idx[stvc_pkg::PinAw-1:0]], DW'(0)};
            end
            stvc_pkg::OP_EP_RD: begin
                vm_re  = !app;
                vm_we  = app && !vfull;
                vm_wa  = r_vcnt[stvc_pkg::VertAw-1:0];
                end_we = app && !vfull;
            end
            stvc_pkg::OP_EP_CHK: begin
                vm_we  = match;
                vm_wd  = {r_point, deg + DW'(1)};
                end_we = match;
                end_wd = r_idx[stvc_pkg::VertAw-1:0];
            end
            stvc_pkg::OP_DEG_RD: begin
                vm_re = !deg_end;
                sm_we = deg_end && !cnt_bad;
                sm_wa = '0;
                sm_wd = start_v;
            end
            stvc_pkg::OP_WALK: begin
                sm_we = w_hit && (r_sp <= stvc_pkg::StackCw'(stvc_pkg::MaxEdges));
                sm_re = w_end && !sp_last;
            end
            default: begin
                vm_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (vm_we) vmem[vm_wa] <= vm_wd;
        if (vm_re) r_vrd <= vmem[vm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sm_we) smem[sm_wa] <= sm_wd;
        if (sm_re) r_srd <= smem[sm_ra];
    end

    // Pin, edge and endpoint tables.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == stvc_pkg::OP_PIN &&
            r_pin_cnt < stvc_pkg::PinCw'(stvc_pkg::MaxPins)) begin
            r_pin[r_pin_cnt[stvc_pkg::PinAw-1:0]] <= pt1;
        end
        if (i_cmd.op == stvc_pkg::OP_INS) begin
            r_edge[pos] <= ins_shift ? es_prev : r_key;
        end
        if (end_we) begin
            if (r_side) r_end1[e5] <= end_wd;
            else        r_end0[e5] <= end_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_cnt  <= '0;
            r_edge_cnt <= '0;
            r_ovf      <= 1'b0;
            r_used     <= '0;
            r_seen     <= '0;
            r_vcnt     <= '0;
            r_idx      <= '0;
            r_e        <= '0;
            r_side     <= 1'b0;
            r_point    <= '0;
            r_key      <= '0;
            r_prev     <= '0;
            r_cur      <= '0;
            r_first    <= '0;
            r_first_ok <= 1'b0;
            r_sp       <= '0;
            r_reason   <= stvc_pkg::RSN_OK;
            r_valid    <= 1'b0;
            r_ok       <= 1'b0;
            r_fr       <= stvc_pkg::RSN_OK;
        end else begin
            r_valid <= (i_cmd.op == stvc_pkg::OP_EMIT);
            case (i_cmd.op)
                stvc_pkg::OP_PIN: begin
                    if (r_pin_cnt >= stvc_pkg::PinCw'(stvc_pkg::MaxPins)) r_ovf <= 1'b1;
                    else r_pin_cnt <= r_pin_cnt + 1'b1;
                end
                stvc_pkg::OP_EDGE_START: begin
                    if (o_status.full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_key <= key_in;
                        r_idx <= stvc_pkg::IdxW'(r_edge_cnt);
                    end
                end
                stvc_pkg::OP_INS: begin
                    if (ins_shift) r_idx <= r_idx - 1'b1;
                    else r_edge_cnt <= r_edge_cnt + 1'b1;
                end
                stvc_pkg::OP_EVAL_START: begin
                    r_reason   <= stvc_pkg::RSN_OVERFLOW;
                    r_idx      <= '0;
                    r_vcnt     <= '0;
                    r_seen     <= '0;
                    r_used     <= '0;
                    r_first_ok <= 1'b0;
                end
                stvc_pkg::OP_DUP: begin
                    r_prev <= es_cur;
                    if (dup_hit) r_reason <= stvc_pkg::RSN_DUPLICATE;
                    r_idx <= dup_end ? '0 : r_idx + 1'b1;
                end
                stvc_pkg::OP_COPY: begin
                    if (!copy_end) begin
                        r_vcnt <= r_vcnt + 1'b1;
                        r_idx  <= r_idx + 1'b1;
                    end else begin
                        r_e    <= '0;
                        r_side <= 1'b0;
                    end
                end
                stvc_pkg::OP_EP_SET: begin
                    r_point <= r_side ? es_e[PW-1:0] : es_e[stvc_pkg::KeyW-1:PW];
                    r_idx   <= '0;
                end
                stvc_pkg::OP_EP_RD: begin
                    if (app) begin
                        if (vfull) begin
                            r_reason <= stvc_pkg::RSN_OVERFLOW;
                        end else begin
                            r_vcnt <= r_vcnt + 1'b1;
                            r_side <= !r_side;
                            if (r_side) r_e <= r_e + 1'b1;
                        end
                    end
                end
                stvc_pkg::OP_EP_CHK: begin
                    if (match) begin
                        r_side <= !r_side;
                        if (r_side) r_e <= r_e + 1'b1;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                stvc_pkg::OP_DEG_RD: begin
                    if (deg_end) begin
                        if (cnt_bad) begin
                            r_reason <= stvc_pkg::RSN_COUNT;
                        end else begin
                            r_cur          <= start_v;
                            r_seen[start_v] <= 1'b1;
                            r_sp           <= stvc_pkg::StackCw'(1);
                            r_e            <= '0;
                        end
                    end
                end
                stvc_pkg::OP_DEG_CHK: begin
                    if (bad_deg) r_reason <= stvc_pkg::RSN_DEGREE;
                    if (deg == DW'(1) && !r_first_ok) begin
                        r_first    <= r_idx[stvc_pkg::VertAw-1:0];
                        r_first_ok <= 1'b1;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                stvc_pkg::OP_WALK: begin
                    if (w_end) begin
                        if (sp_last) begin
                            r_reason <= pins_ok ? stvc_pkg::RSN_OK : stvc_pkg::RSN_UNREACHED;
                        end else begin
                            r_sp <= r_sp - 1'b1;
                        end
                    end else if (w_hit) begin
                        r_used[e5] <= 1'b1;
                        if (r_sp <= stvc_pkg::StackCw'(stvc_pkg::MaxEdges)) r_sp <= r_sp + 1'b1;
                        if (r_seen[nxt]) r_reason <= stvc_pkg::RSN_CYCLE;
                        r_seen[nxt] <= 1'b1;
                        r_cur       <= nxt;
                        r_e         <= '0;
                    end else begin
                        r_e <= r_e + 1'b1;
                    end
                end
                stvc_pkg::OP_POP: begin
                    r_cur <= r_srd;
                    r_e   <= '0;
                end
                stvc_pkg::OP_EMIT: begin
                    r_ok       <= r_reason == stvc_pkg::RSN_OK;
                    r_fr       <= r_reason;
                    r_pin_cnt  <= '0;
                    r_edge_cnt <= '0;
                    r_ovf      <= 1'b0;
                    r_used     <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid       = r_valid;
    assign o_tree_ok     = r_ok;
    assign o_fail_reason = r_fr;

endmodule
`default_nettype wire
